// File: rtl/flm_pkg.sv
// ----------------------------------------------------------------------------
// flm_pkg
// Shared widths, opcodes, status codes and control types of the lock manager.
// ----------------------------------------------------------------------------
package flm_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned MEMBER_W = 8;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned WAIT_DEPTH_DEF  = 16;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [OPCODE_W-1:0] OP_LOCK   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_UNLOCK = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNLOCK_FREE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;   // capture the accepted request
    logic commit;  // update lock state and load the result register
  } flm_cmd_t;

endpackage

// File: rtl/flm_if.sv
// ----------------------------------------------------------------------------
// flm_if
// Request and result channels of the lock manager (valid/ready handshake).
// ----------------------------------------------------------------------------
interface flm_req_if
  import flm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [MEMBER_W-1:0] requester;
  logic                recursive_mode;

  modport source (output valid, output opcode, output requester,
                  output recursive_mode, input ready);
  modport sink   (input valid, input opcode, input requester,
                  input recursive_mode, output ready);
endinterface

interface flm_rsp_if
  import flm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                granted;
  logic [MEMBER_W-1:0] granted_member;
  logic                owner_held;
  logic [MEMBER_W-1:0] owner_member;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted, output granted_member,
                  output owner_held, output owner_member, output status,
                  input ready);
  modport sink   (input valid, input granted, input granted_member,
                  input owner_held, input owner_member, input status,
                  output ready);
endinterface

// File: rtl/flm_ram.sv
// ----------------------------------------------------------------------------
// flm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module flm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/flm_ctrl.sv
// ----------------------------------------------------------------------------
// flm_ctrl
// Sequencer: accept a request, execute it once RAM data is back, hold result.
// ----------------------------------------------------------------------------
module flm_ctrl
  import flm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output flm_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic commit;

  assign in_ready_o = (state_q == S_IDLE);
  // Execute only when the result register is free or draining this cycle.
  assign commit = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cmd_o.latch  = in_ready_o && in_valid_i;
  assign cmd_o.commit = commit;

endmodule

// File: rtl/flm_dp.sv
// ----------------------------------------------------------------------------
// flm_dp
// Lock state, owner stack and waiter FIFO, and the result register.
// ----------------------------------------------------------------------------
module flm_dp
  import flm_pkg::*;
#(
  parameter int unsigned WAIT_DEPTH  = WAIT_DEPTH_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  flm_cmd_t            cmd_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [MEMBER_W-1:0] requester_i,
  input  logic                recursive_mode_i,
  output logic                granted_o,
  output logic [MEMBER_W-1:0] granted_member_o,
  output logic                owner_held_o,
  output logic [MEMBER_W-1:0] owner_member_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned QPW = $clog2(WAIT_DEPTH);
  localparam int unsigned QCW = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned SPW = $clog2(STACK_DEPTH);
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);

  localparam logic [QCW-1:0] QCNT_MAX  = QCW'(WAIT_DEPTH);
  localparam logic [QPW-1:0] QPTR_LAST = QPW'(WAIT_DEPTH - 1);
  localparam logic [SCW-1:0] SCNT_MAX  = SCW'(STACK_DEPTH);

  // Latched request
  logic [OPCODE_W-1:0] op_q;
  logic [MEMBER_W-1:0] req_q;
  logic                rec_q;

  // Lock state
  logic [MEMBER_W-1:0] plain_owner_q, plain_owner_d;
  logic                plain_held_q, plain_held_d;
  logic [MEMBER_W-1:0] top_q, top_d;
  logic [SCW-1:0]      scnt_q, scnt_d;
  logic [QPW-1:0]      qhead_q, qhead_d;
  logic [QPW-1:0]      qtail_q, qtail_d;
  logic [QCW-1:0]      qcnt_q, qcnt_d;

  // Result register
  logic                granted_q, granted_d;
  logic [MEMBER_W-1:0] gm_q, gm_d;
  logic                held_q, held_d;
  logic [MEMBER_W-1:0] owner_q, owner_d;
  logic [STATUS_W-1:0] status_q, status_d;

  // RAM ports
  logic                s_we, q_we;
  logic [SPW-1:0]      s_waddr, s_raddr;
  logic [MEMBER_W-1:0] s_wdata, s_rdata, q_rdata;
  logic [SCW-1:0]      scnt_minus2;

  // Read the entry below the top, and the FIFO head, for the next step.
  assign scnt_minus2 = scnt_q - SCW'(2);
  assign s_raddr     = scnt_minus2[SPW-1:0];

  flm_ram #(.WIDTH(MEMBER_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  flm_ram #(.WIDTH(MEMBER_W), .DEPTH(WAIT_DEPTH)) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(qtail_q),
    .wdata_i(req_q),
    .raddr_i(qhead_q),
    .rdata_o(q_rdata)
  );

  always_comb begin
    plain_owner_d = plain_owner_q;
    plain_held_d  = plain_held_q;
    top_d         = top_q;
    scnt_d        = scnt_q;
    qhead_d       = qhead_q;
    qtail_d       = qtail_q;
    qcnt_d        = qcnt_q;
    granted_d     = 1'b0;
    gm_d          = '0;
    status_d      = ST_OK;
    s_we          = 1'b0;
    s_waddr       = scnt_q[SPW-1:0];
    s_wdata       = req_q;
    q_we          = 1'b0;

    case (op_q)
      OP_LOCK: begin
        if (rec_q && (scnt_q == '0 || top_q == req_q)) begin
          if (scnt_q < SCNT_MAX) begin
            s_we      = 1'b1;
            scnt_d    = scnt_q + SCW'(1);
            top_d     = req_q;
            granted_d = 1'b1;
            gm_d      = req_q;
          end else begin
            status_d = ST_STACK_FULL;
          end
        end else if (!rec_q && !plain_held_q) begin
          plain_owner_d = req_q;
          plain_held_d  = 1'b1;
          granted_d     = 1'b1;
          gm_d          = req_q;
        end else if (qcnt_q < QCNT_MAX) begin
          // queue the requester
          q_we    = 1'b1;
          qtail_d = (qtail_q == QPTR_LAST) ? '0 : qtail_q + QPW'(1);
          qcnt_d  = qcnt_q + QCW'(1);
        end else begin
          status_d = ST_QUEUE_FULL;
        end
      end
      OP_UNLOCK: begin
        if (rec_q) begin
          if (scnt_q == '0) begin
            status_d = ST_UNLOCK_FREE;
          end else if (scnt_q != SCW'(1)) begin
            scnt_d = scnt_q - SCW'(1);
            top_d  = s_rdata;
          end else if (qcnt_q != '0) begin
            // stack empties: hand it to the head waiter
            s_we      = 1'b1;
            s_waddr   = '0;
            s_wdata   = q_rdata;
            top_d     = q_rdata;
            qhead_d   = (qhead_q == QPTR_LAST) ? '0 : qhead_q + QPW'(1);
            qcnt_d    = qcnt_q - QCW'(1);
            granted_d = 1'b1;
            gm_d      = q_rdata;
          end else begin
            scnt_d = '0;
          end
        end else begin
          if (!plain_held_q) begin
            status_d = ST_UNLOCK_FREE;
          end else if (qcnt_q != '0) begin
            plain_owner_d = q_rdata;
            qhead_d       = (qhead_q == QPTR_LAST) ? '0 : qhead_q + QPW'(1);
            qcnt_d        = qcnt_q - QCW'(1);
            granted_d     = 1'b1;
            gm_d          = q_rdata;
          end else begin
            plain_held_d  = 1'b0;
            plain_owner_d = '0;
          end
        end
      end
      default: begin
        // query owner: no state change
      end
    endcase

    if (rec_q) begin
      held_d  = (scnt_d != '0);
      owner_d = held_d ? top_d : '0;
    end else begin
      held_d  = plain_held_d;
      owner_d = held_d ? plain_owner_d : '0;
    end

    if (!cmd_i.commit) begin
      s_we = 1'b0;
      q_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_owner_q <= '0;
      plain_held_q  <= 1'b0;
      top_q         <= '0;
      scnt_q        <= '0;
      qhead_q       <= '0;
      qtail_q       <= '0;
      qcnt_q        <= '0;
    end else if (cmd_i.commit) begin
      plain_owner_q <= plain_owner_d;
      plain_held_q  <= plain_held_d;
      top_q         <= top_d;
      scnt_q        <= scnt_d;
      qhead_q       <= qhead_d;
      qtail_q       <= qtail_d;
      qcnt_q        <= qcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= opcode_i;
      req_q <= requester_i;
      rec_q <= recursive_mode_i;
    end
    if (cmd_i.commit) begin
      granted_q <= granted_d;
      gm_q      <= gm_d;
      held_q    <= held_d;
      owner_q   <= owner_d;
      status_q  <= status_d;
    end
  end

  assign granted_o        = granted_q;
  assign granted_member_o = gm_q;
  assign owner_held_o     = held_q;
  assign owner_member_o   = owner_q;
  assign status_o         = status_q;

endmodule

// File: rtl/fifo_lock_manager_unit.sv
// A result is registered in the execute state once the result register is free;
// a stalled result holds the controller in the execute state.
// A request is taken only in the idle state, so the registered read of the
// owner-stack and waiter-FIFO RAMs completes ahead of the execute state.
// A new request is accepted while the previous result still waits.
// Reset clears the lock state, stack and FIFO counts at once; RAM contents
// are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// fifo_lock_manager_unit
// FIFO-queued lock manager with a plain lock and a recursive lock.
// ----------------------------------------------------------------------------
module fifo_lock_manager_unit
  import flm_pkg::*;
#(
  parameter int unsigned WAIT_DEPTH  = WAIT_DEPTH_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  flm_req_if.sink   in_i,
  flm_rsp_if.source out_o
);

  flm_cmd_t cmd;
  logic     in_ready;
  logic     out_valid;

  flm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(out_o.ready),
    .cmd_o      (cmd)
  );

  flm_dp #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .opcode_i        (in_i.opcode),
    .requester_i     (in_i.requester),
    .recursive_mode_i(in_i.recursive_mode),
    .granted_o       (out_o.granted),
    .granted_member_o(out_o.granted_member),
    .owner_held_o    (out_o.owner_held),
    .owner_member_o  (out_o.owner_member),
    .status_o        (out_o.status)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
